// ===== hdl/rc4_stream_cipher_top_assert.svh =====
// Assertion macros shared by the engine modules.
// Each macro expects signals named clock and reset in the calling module.
`ifndef RC4_STREAM_CIPHER_TOP_ASSERT_SVH
`define RC4_STREAM_CIPHER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RC4_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rc4_pkg.sv =====
`timescale 1ns / 1ps

package rc4_pkg;

   localparam int BYTE_W        = 8;
   localparam int SBOX_DEPTH    = 256;
   localparam int MAX_KEY_BYTES = 256;
   localparam int KEY_CNT_W     = 9;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_KEY,
      CMD_KEY_LAST,
      CMD_DATA
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [BYTE_W-1:0]   data_byte;
      logic                last;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DATA_J,
      ST_DATA_K,
      ST_DATA_FIN,
      ST_KS_A,
      ST_KS_B,
      ST_KS_C,
      ST_KS_D
   } state_type;

endpackage

// ===== hdl/rc4_stream_cipher_top.sv =====
`timescale 1ns / 1ps
// Data word: three dependent reads (S[i], S[j], S[t]) on the single S-box read port, then
// ST_DATA_FIN loads the result once the output is free; the next word waits for it.
// Key word: a single queue pop. Last key word: 256-step swap pass, ST_KS_B to ST_KS_D.
// Reset: S-box reads as the identity through per-entry valid bits, both indexes and the
// key count are zero, the input queue and output register are empty; no clearing pass.

module rc4_stream_cipher_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_func,
   input  logic [rc4_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rc4_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_out_last
);
   import rc4_pkg::*;

   qhead_type q_head;
   logic      q_pop;

   rc4_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .q_head        (q_head),
      .q_pop         (q_pop)
   );

   rc4_core u_core (
      .clock        (clock),
      .reset        (reset),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

// ===== hdl/rc4_front.sv =====
`timescale 1ns / 1ps

module rc4_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_func,
   input  logic [rc4_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                       req_last,
   output rc4_pkg::qhead_type         q_head,
   input  logic                       q_pop
);
   import rc4_pkg::*;

   `include "rc4_stream_cipher_top_assert.svh"

   item_type            q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   fill_ff;
   logic [QCNT_W-1:0]   fill_in;
   item_type            req_item;
   logic                push;

   // Sort each incoming word into a key byte, the key byte that ends a key, or data.
   always_comb begin
      req_item.data_byte = req_data_byte;
      req_item.last      = req_last;
      if (req_func) begin
         req_item.cmd = CMD_DATA;
      end else if (req_last) begin
         req_item.cmd = CMD_KEY_LAST;
      end else begin
         req_item.cmd = CMD_KEY;
      end
   end

   assign req_stall    = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign push         = req_valid && !req_stall;
   assign q_head.valid = (fill_ff != '0);
   assign q_head.item  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !q_pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (!push && q_pop) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= req_item;
      end
   end

   `RC4_ASSERT_SAME(a_fill_range, 1'b1, fill_ff <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
   `RC4_ASSERT_SAME(a_pop_nonempty, q_pop, fill_ff != '0, "pop from an empty queue")
   `RC4_ASSERT_NEXT(a_fill_grow, push && !q_pop, fill_ff == $past(fill_ff) + QCNT_W'(1),
                    "queue fill did not track a push")

endmodule

// ===== hdl/rc4_core.sv =====
`timescale 1ns / 1ps

module rc4_core (
   input  logic                       clock,
   input  logic                       reset,
   input  rc4_pkg::qhead_type         q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rc4_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_out_last
);
   import rc4_pkg::*;

   `include "rc4_stream_cipher_top_assert.svh"

   state_type              state_ff, state_in;
   logic [BYTE_W-1:0]      i_ff, i_in;
   logic [BYTE_W-1:0]      j_ff, j_in;
   logic [BYTE_W-1:0]      si_ff, si_in;
   logic [BYTE_W-1:0]      t_ff, t_in;
   logic [BYTE_W-1:0]      dbyte_ff, dbyte_in;
   logic                   dlast_ff, dlast_in;
   logic [KEY_CNT_W-1:0]   count_ff, count_in;
   logic [KEY_CNT_W-1:0]   len_ff, len_in;
   logic [BYTE_W-1:0]      kp_ff, kp_in;

   logic [BYTE_W-1:0]      sbox_mem [SBOX_DEPTH];
   logic [SBOX_DEPTH-1:0]  sb_valid_ff;
   logic [BYTE_W-1:0]      sb_rdata_ff;
   logic                   sb_hit_ff;
   logic [BYTE_W-1:0]      sb_raddr_ff;
   logic [BYTE_W-1:0]      sb_raddr;
   logic                   sb_we;
   logic [BYTE_W-1:0]      sb_waddr;
   logic [BYTE_W-1:0]      sb_wdata;
   logic                   sb_clear;
   logic [BYTE_W-1:0]      sb_rd;

   logic [BYTE_W-1:0]      key_mem [MAX_KEY_BYTES];
   logic [BYTE_W-1:0]      key_rdata_ff;
   logic                   key_we;

   logic                   rsp_valid_ff;
   logic [BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_load;

   logic                   dispatch;
   logic                   out_free;
   logic                   key_room;
   logic [BYTE_W-1:0]      ks;

   // An S-box entry that has not been written since the last clear holds its own index.
   assign sb_rd    = sb_hit_ff ? sb_rdata_ff : sb_raddr_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign key_room = (count_ff < KEY_CNT_W'(MAX_KEY_BYTES));
   // S[j] is rewritten only after the keystream read, so a keystream index equal to j
   // takes the swapped value from the register instead.
   assign ks       = (t_ff == j_ff) ? si_ff : sb_rd;

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      si_in       = si_ff;
      t_in        = t_ff;
      dbyte_in    = dbyte_ff;
      dlast_in    = dlast_ff;
      count_in    = count_ff;
      len_in      = len_ff;
      kp_in       = kp_ff;
      q_pop       = 1'b0;
      sb_raddr    = t_ff;
      sb_we       = 1'b0;
      sb_waddr    = i_ff;
      sb_wdata    = si_ff;
      sb_clear    = 1'b0;
      key_we      = 1'b0;
      rsp_load    = 1'b0;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      dispatch    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            dispatch = 1'b1;
         end
         ST_DATA_J: begin
            si_in    = sb_rd;
            j_in     = j_ff + sb_rd;
            sb_raddr = j_in;
            state_in = ST_DATA_K;
         end
         ST_DATA_K: begin
            sb_we    = 1'b1;
            sb_waddr = i_ff;
            sb_wdata = sb_rd;
            t_in     = si_ff + sb_rd;
            sb_raddr = t_in;
            state_in = ST_DATA_FIN;
         end
         ST_DATA_FIN: begin
            // The keystream read repeats at t while the output register is blocked.
            if (out_free) begin
               sb_we       = 1'b1;
               sb_waddr    = j_ff;
               sb_wdata    = si_ff;
               rsp_load    = 1'b1;
               rsp_byte_in = dbyte_ff ^ ks;
               rsp_last_in = dlast_ff;
               state_in    = ST_IDLE;
               dispatch    = 1'b1;
            end
         end
         ST_KS_A: begin
            sb_raddr = i_ff;
            state_in = ST_KS_B;
         end
         ST_KS_B: begin
            si_in    = sb_rd;
            j_in     = j_ff + sb_rd + key_rdata_ff;
            sb_raddr = j_in;
            state_in = ST_KS_C;
         end
         ST_KS_C: begin
            sb_we    = 1'b1;
            sb_waddr = i_ff;
            sb_wdata = sb_rd;
            state_in = ST_KS_D;
         end
         ST_KS_D: begin
            sb_we    = 1'b1;
            sb_waddr = j_ff;
            sb_wdata = si_ff;
            if (i_ff == BYTE_W'(SBOX_DEPTH - 1)) begin
               i_in     = '0;
               j_in     = '0;
               state_in = ST_IDLE;
            end else begin
               i_in     = i_ff + BYTE_W'(1);
               sb_raddr = i_in;
               if (({1'b0, kp_ff} + KEY_CNT_W'(1)) >= len_ff) begin
                  kp_in = '0;
               end else begin
                  kp_in = kp_ff + BYTE_W'(1);
               end
               state_in = ST_KS_B;
            end
         end
      endcase

      if (dispatch && q_head.valid) begin
         q_pop = 1'b1;
         unique case (q_head.item.cmd)
            CMD_KEY: begin
               if (key_room) begin
                  key_we   = 1'b1;
                  count_in = count_ff + KEY_CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
            CMD_KEY_LAST: begin
               key_we   = key_room;
               len_in   = key_room ? count_ff + KEY_CNT_W'(1) : count_ff;
               count_in = '0;
               sb_clear = 1'b1;
               i_in     = '0;
               j_in     = '0;
               kp_in    = '0;
               state_in = ST_KS_A;
            end
            CMD_DATA: begin
               i_in     = i_ff + BYTE_W'(1);
               sb_raddr = i_in;
               dbyte_in = q_head.item.data_byte;
               dlast_in = q_head.item.last;
               state_in = ST_DATA_J;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      t_ff        <= t_in;
      dbyte_ff    <= dbyte_in;
      dlast_ff    <= dlast_in;
      len_ff      <= len_in;
      kp_ff       <= kp_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // S-box storage: one write and one read port, write-first on a same-address access.
   always_ff @(posedge clock) begin
      if (sb_we) begin
         sbox_mem[sb_waddr] <= sb_wdata;
      end
      if (sb_we && (sb_waddr == sb_raddr)) begin
         sb_rdata_ff <= sb_wdata;
      end else begin
         sb_rdata_ff <= sbox_mem[sb_raddr];
      end
      sb_hit_ff   <= (sb_we && (sb_waddr == sb_raddr)) || sb_valid_ff[sb_raddr];
      sb_raddr_ff <= sb_raddr;
   end

   always_ff @(posedge clock) begin
      if (reset || sb_clear) begin
         sb_valid_ff <= '0;
      end else if (sb_we) begin
         sb_valid_ff[sb_waddr] <= 1'b1;
      end
   end

   // Key storage. The read address runs one step ahead so the byte is ready in ST_KS_B.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[count_ff[BYTE_W-1:0]] <= q_head.item.data_byte;
      end
      key_rdata_ff <= key_mem[kp_in];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   `RC4_ASSERT_SAME(a_key_count_range, 1'b1, count_ff <= KEY_CNT_W'(MAX_KEY_BYTES),
                    "key count beyond the key store")
   `RC4_ASSERT_SAME(a_kp_in_key, state_ff == ST_KS_B,
                    (len_ff != '0) && ({1'b0, kp_ff} < len_ff), "key pointer outside the key")
   `RC4_ASSERT_SAME(a_rsp_load_free, rsp_load, out_free,
                    "result loaded over a word that was not taken")

endmodule
